// File: rtl/sfc_pkg.sv
// shared types and constants of the stun frame checker
`timescale 1ns / 1ps

package sfc_pkg;

    localparam int HEADER_BYTES = 20;
    localparam logic [16:0] COUNT_MAX = 17'h1FFFF;
    localparam logic [8:0] ATTR_COUNT_MAX = 9'h1FF;
    localparam logic [8:0] MAX_SLOTS_RESET = 9'd32;
    localparam logic [7:0] LEAD_BITS_MASK = 8'hC0;
    localparam logic [7:0] LENGTH_BITS_MASK = 8'h03;

    localparam logic [7:0] COOKIE_BYTES [4] = '{8'h21, 8'h12, 8'hA4, 8'h42};

    typedef enum logic [3:0] {
        ERR_OK        = 4'd0,
        ERR_SHORT     = 4'd1,
        ERR_UNALIGNED = 4'd2,
        ERR_LEAD_BITS = 4'd3,
        ERR_LEN_BITS  = 4'd4,
        ERR_COOKIE    = 4'd5,
        ERR_LEN_MISMATCH = 4'd6,
        ERR_SLOTS     = 4'd7,
        ERR_TRUNCATED = 4'd8
    } err_code_t;

    typedef enum logic {
        KIND_ATTR    = 1'b0,
        KIND_VERDICT = 1'b1
    } record_kind_t;

    typedef struct packed {
        logic cookie;
        logic slots;
        logic sat;
    } err_flags_t;

    typedef struct packed {
        record_kind_t kind;
        logic [15:0]  attr_offset;
        logic [15:0]  attr_type;
        logic [15:0]  attr_length;
        logic         frame_ok;
        err_code_t    error_code;
        logic [11:0]  method;
        logic [1:0]   msg_class;
        logic [8:0]   attr_count;
        logic         end_of_run;
    } result_t;

endpackage

// File: rtl/stun_frame_checker_core.sv
// stun frame checker top level: header checks, attribute walk and result queue
`timescale 1ns / 1ps
//
// Takes a STUN message one byte per item on s_axis, tlast on the final byte.
// Each completed attribute header gives an attribute record (tuser 0), and the
// final byte gives a frame verdict (tuser 1); a byte gives none, one or both,
// record first. tlast on m_axis marks the last result caused by one byte.
// Records are only meaningful when the verdict says frame_ok.
// max_slots is to be written through the cfg channel only while the block is
// idle; the block itself does not enforce this. Throughput: one byte per cycle
// while s_axis_tready is high; all per-byte work is combinational counter and
// compare logic against the frame state registers.
// Results go through a four-entry queue; s_axis_tready drops while fewer than
// two entries are free, so a stalled receiver backs up the byte stream and
// nothing is lost.
// Reset clears the frame state and the queue and sets max_slots to 32.
//
module stun_frame_checker_core
    import sfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // attr_offset, attr_type, attr_length, frame_ok, error_code, method,
    // msg_class, attr_count, zero fill
    output logic [79:0] m_axis_tdata,
    output logic        m_axis_tuser,   // record_kind
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data        // max_slots
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [16:0] byte_count_reg, byte_count_next;
    logic [31:0] header_reg, header_next;
    logic [15:0] decl_len_reg, decl_len_next;
    logic [1:0]  ahp_reg, ahp_next;
    logic [15:0] type_hold_reg, type_hold_next;
    logic [16:0] body_rem_reg, body_rem_next;
    logic [8:0]  attrs_reg, attrs_next;
    err_flags_t  flags_reg, flags_next;
    logic [8:0]  max_slots_reg;

    result_t queue_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic        accept;
    logic        pop;
    logic        rec_valid;
    logic        ver_valid;
    result_t     rec_res;
    result_t     ver_res;
    result_t     first_res;
    logic        push_a;
    logic        push_b;
    logic [1:0]  push_n;
    logic [15:0] len_word;
    logic [16:0] len_pad;
    logic [31:0] full_hdr;
    logic [7:0]  hb0;
    logic [7:0]  hb1;
    logic [16:0] expected_len;
    err_code_t   code;
    logic [PTR_W-1:0] wr_ptr_b;

    assign accept = s_axis_tvalid && s_axis_tready;
    assign pop = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = count_reg <= CNT_W'(DEPTH - 2);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        byte_count_next = byte_count_reg;
        header_next = header_reg;
        decl_len_next = decl_len_reg;
        ahp_next = ahp_reg;
        type_hold_next = type_hold_reg;
        body_rem_next = body_rem_reg;
        attrs_next = attrs_reg;
        flags_next = flags_reg;
        rec_valid = 1'b0;
        ver_valid = 1'b0;
        rec_res = '0;
        ver_res = '0;
        len_word = {body_rem_reg[7:0], s_axis_tdata};
        len_pad = 17'({1'b0, len_word} + 17'd3) & 17'h1FFFC;
        full_hdr = '0;
        hb0 = '0;
        hb1 = '0;
        expected_len = 17'(HEADER_BYTES) + {1'b0, decl_len_reg};
        code = ERR_OK;

        if (accept)
        begin
            if (byte_count_reg < 17'd4)
            begin
                header_next = {header_reg[23:0], s_axis_tdata};
                if (byte_count_reg == 17'd2)
                begin
                    decl_len_next = {s_axis_tdata, 8'h00};
                end
                if (byte_count_reg == 17'd3)
                begin
                    decl_len_next = {decl_len_reg[15:8], s_axis_tdata};
                end
            end
            else if (byte_count_reg < 17'd8)
            begin
                if (s_axis_tdata != COOKIE_BYTES[byte_count_reg[1:0]])
                begin
                    flags_next.cookie = 1'b1;
                end
            end
            else if (byte_count_reg >= 17'(HEADER_BYTES))
            begin
                if (ahp_reg == 2'd0 && body_rem_reg != 17'd0)
                begin
                    body_rem_next = body_rem_reg - 17'd1;
                end
                else
                begin
                    case (ahp_reg)
                        2'd0:
                        begin
                            if (attrs_reg < ATTR_COUNT_MAX)
                            begin
                                attrs_next = attrs_reg + 9'd1;
                            end
                            if (attrs_next == max_slots_reg)
                            begin
                                flags_next.slots = 1'b1;
                            end
                            type_hold_next = {s_axis_tdata, 8'h00};
                            ahp_next = 2'd1;
                        end
                        2'd1:
                        begin
                            type_hold_next = {type_hold_reg[15:8], s_axis_tdata};
                            ahp_next = 2'd2;
                        end
                        2'd2:
                        begin
                            body_rem_next = {9'd0, s_axis_tdata};
                            ahp_next = 2'd3;
                        end
                        default:
                        begin
                            rec_valid = 1'b1;
                            rec_res.kind = KIND_ATTR;
                            rec_res.attr_offset = 16'(byte_count_reg - 17'd3);
                            rec_res.attr_type = type_hold_reg;
                            rec_res.attr_length = len_word;
                            rec_res.end_of_run = !s_axis_tlast;
                            body_rem_next = len_pad;
                            ahp_next = 2'd0;
                        end
                    endcase
                end
            end

            if (byte_count_reg < COUNT_MAX)
            begin
                byte_count_next = byte_count_reg + 17'd1;
            end
            else
            begin
                flags_next.sat = 1'b1;
            end

            if (s_axis_tlast)
            begin
                // bytes of the header not received count as zero
                case (byte_count_next)
                    17'd1: full_hdr = {header_next[7:0], 24'h0};
                    17'd2: full_hdr = {header_next[15:0], 16'h0};
                    17'd3: full_hdr = {header_next[23:0], 8'h0};
                    default: full_hdr = header_next;
                endcase
                hb0 = full_hdr[31:24];
                hb1 = full_hdr[23:16];
                expected_len = 17'(HEADER_BYTES) + {1'b0, decl_len_next};

                if (!flags_next.sat && byte_count_next < 17'(HEADER_BYTES))
                begin
                    code = ERR_SHORT;
                end
                else if (!flags_next.sat && byte_count_next[1:0] != 2'd0)
                begin
                    code = ERR_UNALIGNED;
                end
                else if ((hb0 & LEAD_BITS_MASK) != 8'h00)
                begin
                    code = ERR_LEAD_BITS;
                end
                else if ((full_hdr[7:0] & LENGTH_BITS_MASK) != 8'h00)
                begin
                    code = ERR_LEN_BITS;
                end
                else if (flags_next.cookie)
                begin
                    code = ERR_COOKIE;
                end
                else if (flags_next.sat || byte_count_next != expected_len)
                begin
                    code = ERR_LEN_MISMATCH;
                end
                else if (flags_next.slots)
                begin
                    code = ERR_SLOTS;
                end
                else if (ahp_next != 2'd0 || body_rem_next != 17'd0)
                begin
                    code = ERR_TRUNCATED;
                end
                else
                begin
                    code = ERR_OK;
                end

                ver_valid = 1'b1;
                ver_res.kind = KIND_VERDICT;
                ver_res.frame_ok = code == ERR_OK;
                ver_res.error_code = code;
                ver_res.method = {hb0[5:1], hb1[7:5], hb1[3:0]};
                ver_res.msg_class = {hb0[0], hb1[4]};
                ver_res.attr_count = attrs_next;
                ver_res.end_of_run = 1'b1;

                // verdict ends the frame
                byte_count_next = '0;
                header_next = '0;
                decl_len_next = '0;
                ahp_next = '0;
                type_hold_next = '0;
                body_rem_next = '0;
                attrs_next = '0;
                flags_next = '0;
            end
        end
    end

    assign push_a = rec_valid || ver_valid;
    assign push_b = rec_valid && ver_valid;
    assign push_n = {1'b0, push_a} + {1'b0, push_b};
    assign first_res = rec_valid ? rec_res : ver_res;
    assign wr_ptr_b = wr_ptr_reg + PTR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            header_reg <= '0;
            decl_len_reg <= '0;
            ahp_reg <= '0;
            type_hold_reg <= '0;
            body_rem_reg <= '0;
            attrs_reg <= '0;
            flags_reg <= '0;
            max_slots_reg <= MAX_SLOTS_RESET;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            header_reg <= header_next;
            decl_len_reg <= decl_len_next;
            ahp_reg <= ahp_next;
            type_hold_reg <= type_hold_next;
            body_rem_reg <= body_rem_next;
            attrs_reg <= attrs_next;
            flags_reg <= flags_next;
            if (cfg_valid && cfg_ready)
            begin
                max_slots_reg <= cfg_data;
            end
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + CNT_W'(push_n) - CNT_W'(pop);
        end
    end

    // result queue entries, up to two written per cycle
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (push_a && wr_ptr_reg == PTR_W'(i))
            begin
                queue_reg[i] <= first_res;
            end
            else if (push_b && wr_ptr_b == PTR_W'(i))
            begin
                queue_reg[i] <= ver_res;
            end
        end
    end

    result_t head;

    assign head = queue_reg[rd_ptr_reg];
    assign m_axis_tvalid = count_reg != '0;
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.end_of_run;
    assign m_axis_tdata = {4'h0, head.attr_count, head.msg_class, head.method,
                           head.error_code, head.frame_ok, head.attr_length,
                           head.attr_type, head.attr_offset};

endmodule
